// ----- sv/bal_pkg.sv -----
// Shared types, operation and status codes for the bounded array list.
package bal_pkg;

    // Default list capacity
    localparam int DEF_CAPACITY = 64;

    // Cells folded into one first-stage gather register
    localparam int GROUP = 8;

    // Field widths of the stream payloads
    localparam int OP_W     = 3;
    localparam int IDX_W    = 7;
    localparam int WORD_W   = 32;
    localparam int CNT_W    = 7;
    localparam int STAT_W   = 2;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 48;

    // Operation codes
    localparam logic [OP_W-1:0] OP_APPEND  = 3'd0;
    localparam logic [OP_W-1:0] OP_PREPEND = 3'd1;
    localparam logic [OP_W-1:0] OP_INSERT  = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE  = 3'd3;
    localparam logic [OP_W-1:0] OP_POP     = 3'd4;
    localparam logic [OP_W-1:0] OP_DEQUEUE = 3'd5;
    localparam logic [OP_W-1:0] OP_READ    = 3'd6;
    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd7;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STAT_W-1:0] ST_BADIDX = 2'd3;

    // Broadcast control to every cell of the chain
    typedef struct packed {
        logic ins;  // open a slot at the position and place the new word there
        logic del;  // close the slot at the position, later words move down
        logic rd;   // cell at the read position drives its word onto the gather
    } t_cell_ctl;

endpackage

// ----- sv/bal_cell.sv -----
// One storage cell of the list chain: holds a word, shifts with its neighbours.
module bal_cell #(
    parameter int CAPACITY = bal_pkg::DEF_CAPACITY,
    parameter int CELL_IDX = 0
) (
    input  logic                        i_clk,
    input  bal_pkg::t_cell_ctl          i_ctl,
    input  logic [$clog2(CAPACITY)-1:0] i_pos,
    input  logic [$clog2(CAPACITY)-1:0] i_rpos,
    input  logic [bal_pkg::WORD_W-1:0]  i_value,
    input  logic [bal_pkg::WORD_W-1:0]  i_left,
    input  logic [bal_pkg::WORD_W-1:0]  i_right,
    output logic [bal_pkg::WORD_W-1:0]  o_word,
    output logic [bal_pkg::WORD_W-1:0]  o_tap
);

    localparam int AW = $clog2(CAPACITY);
    localparam logic [AW-1:0] MY_POS = AW'(CELL_IDX);

    logic [bal_pkg::WORD_W-1:0] r_word;
    logic [bal_pkg::WORD_W-1:0] n_word;

    // Pick the next word: hold, take the new word, or take a neighbour's
    always_comb begin
        n_word = r_word;
        if (i_ctl.ins) begin
            if (MY_POS == i_pos) begin
                n_word = i_value;
            end else if (MY_POS > i_pos) begin
                n_word = i_left;
            end
        end else if (i_ctl.del) begin
            if (MY_POS >= i_pos) begin
                n_word = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    // Drive the gather only when this cell is the one being read
    assign o_tap  = (i_ctl.rd && (i_rpos == MY_POS)) ? r_word : '0;
    assign o_word = r_word;

endmodule

// ----- sv/bounded_array_list.sv -----
// Top level of the bounded array list: decode, cell chain, gather and result register.
//
//  Channel   Dir  Signals                       Payload (lowest bit first)
//  s (ops)   in   i_s_tvalid/o_s_tready/i_s_tdata op[2:0] index[9:3] value[41:10]
//  m (res)   out  o_m_tvalid/i_m_tready/o_m_tdata data[31:0] count[38:32] status[40:39]
//
//  An accepted operation passes the shift state, where the cell chain shifts while the
//  addressed word is gathered per group, and the gather state, which folds groups.
//  Only then is its result shown. The next operation is taken in the cycle its
//  predecessor's result is taken, so none is taken before the last result is taken.
//  A stalled result holds the block; synchronous active-low reset empties it.
module bounded_array_list #(
    parameter int CAPACITY = bal_pkg::DEF_CAPACITY
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [bal_pkg::S_DATA_W-1:0] i_s_tdata,   // op, index, value, zero pad
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [bal_pkg::M_DATA_W-1:0] o_m_tdata    // data, count, status, zero pad
);

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int XW   = (CW > bal_pkg::IDX_W) ? CW : bal_pkg::IDX_W;
    localparam int NGRP = (CAPACITY + bal_pkg::GROUP - 1) / bal_pkg::GROUP;
    localparam int WW   = bal_pkg::WORD_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_GATH = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]                    r_state;
    logic [1:0]                    n_state;
    logic [CW-1:0]                 r_count;
    logic [CW-1:0]                 n_count;
    bal_pkg::t_cell_ctl            r_ctl;
    bal_pkg::t_cell_ctl            n_ctl;
    bal_pkg::t_cell_ctl            w_cell_ctl;
    logic [AW-1:0]                 r_pos;
    logic [AW-1:0]                 n_pos;
    logic [AW-1:0]                 r_rpos;
    logic [AW-1:0]                 n_rpos;
    logic [WW-1:0]                 r_value;
    logic [bal_pkg::STAT_W-1:0]    r_status;
    logic [bal_pkg::STAT_W-1:0]    n_status;
    logic [bal_pkg::CNT_W-1:0]     r_cnt_out;
    logic [WW-1:0]                 r_data;
    logic [WW-1:0]                 r_grp [NGRP];
    logic [WW-1:0]                 w_grp [NGRP];
    logic [WW-1:0]                 w_fold;
    logic [WW-1:0]                 w_word [CAPACITY];
    logic [WW-1:0]                 w_tap  [CAPACITY];

    logic [bal_pkg::OP_W-1:0]      w_op;
    logic [bal_pkg::IDX_W-1:0]     w_idx;
    logic [WW-1:0]                 w_value;
    logic                          w_accept;
    logic                          w_full;
    logic                          w_empty;
    logic [XW-1:0]                 w_idx_x;
    logic [XW-1:0]                 w_cnt_x;

    // Unpack the operation transaction
    assign w_op    = i_s_tdata[2:0];
    assign w_idx   = i_s_tdata[9:3];
    assign w_value = i_s_tdata[41:10];

    // Hold the input not ready while in reset
    assign o_s_tready = i_rst_n &&
                        ((r_state == S_IDLE) || ((r_state == S_OUT) && i_m_tready));
    assign w_accept   = i_s_tvalid && o_s_tready;

    assign w_full  = (r_count >= CW'(CAPACITY));
    assign w_empty = (r_count == '0);
    assign w_idx_x = XW'(w_idx);
    assign w_cnt_x = XW'(r_count);

    // Decode the operation against the current count
    always_comb begin
        n_ctl    = '0;
        n_pos    = '0;
        n_rpos   = '0;
        n_status = bal_pkg::ST_OK;
        n_count  = r_count;
        unique case (w_op) inside
            bal_pkg::OP_APPEND, bal_pkg::OP_PREPEND: begin
                if (w_full) begin
                    n_status = bal_pkg::ST_FULL;
                end else begin
                    n_ctl.ins = 1'b1;
                    n_pos     = (w_op == bal_pkg::OP_APPEND) ? AW'(r_count) : '0;
                    n_count   = r_count + 1'b1;
                end
            end
            bal_pkg::OP_INSERT: begin
                if (w_full) begin
                    n_status = bal_pkg::ST_FULL;
                end else if (w_idx_x > w_cnt_x) begin
                    n_status = bal_pkg::ST_BADIDX;
                end else begin
                    n_ctl.ins = 1'b1;
                    n_pos     = AW'(w_idx);
                    n_count   = r_count + 1'b1;
                end
            end
            bal_pkg::OP_REMOVE, bal_pkg::OP_READ: begin
                if (w_empty) begin
                    n_status = bal_pkg::ST_EMPTY;
                end else if (w_idx_x >= w_cnt_x) begin
                    n_status = bal_pkg::ST_BADIDX;
                end else begin
                    n_ctl.rd = 1'b1;
                    n_rpos   = AW'(w_idx);
                    if (w_op == bal_pkg::OP_REMOVE) begin
                        n_ctl.del = 1'b1;
                        n_pos     = AW'(w_idx);
                        n_count   = r_count - 1'b1;
                    end
                end
            end
            bal_pkg::OP_POP: begin
                if (w_empty) begin
                    n_status = bal_pkg::ST_EMPTY;
                end else begin
                    n_ctl.rd = 1'b1;
                    n_rpos   = AW'(r_count - 1'b1);
                    n_count  = r_count - 1'b1;
                end
            end
            bal_pkg::OP_DEQUEUE: begin
                if (w_empty) begin
                    n_status = bal_pkg::ST_EMPTY;
                end else begin
                    n_ctl.rd  = 1'b1;
                    n_ctl.del = 1'b1;
                    n_count   = r_count - 1'b1;
                end
            end
            default: begin
                n_count = '0;
            end
        endcase
    end

    // Sequence one operation through decode, shift and gather
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: n_state = S_GATH;
            S_GATH: n_state = S_OUT;
            S_OUT: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end else if (i_m_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_count <= n_count;
            end
        end
    end

    // Latch the decoded command and the result fields known at decode
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ctl     <= n_ctl;
            r_pos     <= n_pos;
            r_rpos    <= n_rpos;
            r_value   <= w_value;
            r_status  <= n_status;
            r_cnt_out <= bal_pkg::CNT_W'(n_count);
        end
    end

    // Drive the chain only in the shift cycle
    always_comb begin
        w_cell_ctl     = r_ctl;
        w_cell_ctl.ins = r_ctl.ins && (r_state == S_EXEC);
        w_cell_ctl.del = r_ctl.del && (r_state == S_EXEC);
        w_cell_ctl.rd  = r_ctl.rd  && (r_state == S_EXEC);
    end

    // Chain of storage cells, head at cell 0
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        logic [WW-1:0] w_left;
        logic [WW-1:0] w_right;
        if (gi == 0) begin : g_head
            assign w_left = r_value;
        end else begin : g_mid
            assign w_left = w_word[gi-1];
        end
        if (gi == CAPACITY - 1) begin : g_tail
            assign w_right = w_word[gi];
        end else begin : g_body
            assign w_right = w_word[gi+1];
        end
        bal_cell #(
            .CAPACITY (CAPACITY),
            .CELL_IDX (gi)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_cell_ctl),
            .i_pos   (r_pos),
            .i_rpos  (r_rpos),
            .i_value (r_value),
            .i_left  (w_left),
            .i_right (w_right),
            .o_word  (w_word[gi]),
            .o_tap   (w_tap[gi])
        );
    end

    // Fold the taps of each group of cells
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            w_grp[g] = '0;
            for (int k = 0; k < bal_pkg::GROUP; k++) begin
                if (g * bal_pkg::GROUP + k < CAPACITY) begin
                    w_grp[g] = w_grp[g] | w_tap[g * bal_pkg::GROUP + k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int g = 0; g < NGRP; g++) begin
            r_grp[g] <= w_grp[g];
        end
    end

    // Fold the groups into the result word
    always_comb begin
        w_fold = '0;
        for (int g = 0; g < NGRP; g++) begin
            w_fold = w_fold | r_grp[g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_GATH) begin
            r_data <= w_fold;
        end
    end

    // Result transaction
    assign o_m_tvalid = (r_state == S_OUT);
    assign o_m_tdata  = {7'd0, r_status, r_cnt_out, r_data};

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("element count above capacity");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_EXEC))
        else $error("accepted operation did not enter the shift cycle");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> $stable(r_count))
        else $error("element count changed without an operation");

    a_err_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (r_status != bal_pkg::ST_OK)) |-> (r_data == '0))
        else $error("failed operation returned non-zero data");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (r_status == bal_pkg::ST_FULL)) |-> (r_count == CW'(CAPACITY)))
        else $error("full status with free slots");
`endif

endmodule

// ----- verif/bal_list_checker.sv -----
// Checker for the bounded array list: predicts each operation's result and compares it.
`timescale 1ns / 100ps

module bal_list_checker #(
    parameter int CAPACITY = bal_pkg::DEF_CAPACITY
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    input  logic                         i_s_tready,
    input  logic [bal_pkg::S_DATA_W-1:0] i_s_tdata,    // op, index, value, zero pad
    input  logic                         i_m_tvalid,
    input  logic                         i_m_tready,
    input  logic [bal_pkg::M_DATA_W-1:0] i_m_tdata,    // data, count, status, zero pad
    output int                           o_pending,
    output int                           o_list_count,
    output int                           o_fail_count
);

    // One predicted result, with the operation kept for the report line
    typedef struct {
        logic [bal_pkg::OP_W-1:0]   op;
        logic [bal_pkg::WORD_W-1:0] data;
        logic [bal_pkg::CNT_W-1:0]  count;
        logic [bal_pkg::STAT_W-1:0] status;
    } t_list_result;

    // Own copy of the list contents and fill level
    logic [bal_pkg::WORD_W-1:0] list_words [CAPACITY];
    int                         list_fill = 0;
    t_list_result               pending_results [$];
    int                         fail_total = 0;

    assign o_fail_count = fail_total;

    // Print one mismatch line and count it
    task automatic report_mismatch(input string what,
                                   input logic [bal_pkg::WORD_W-1:0] got,
                                   input logic [bal_pkg::WORD_W-1:0] want);
        $display("%0t: list result mismatch on %s: got 0x%0h, expected 0x%0h",
                 $time, what, got, want);
        fail_total++;
    endtask

    // Apply one operation to the list copy and return the result it gives
    function automatic t_list_result apply_list_op(input logic [bal_pkg::OP_W-1:0] op,
                                                   input logic [bal_pkg::IDX_W-1:0] idx,
                                                   input logic [bal_pkg::WORD_W-1:0] val);
        t_list_result res;
        int           pos;
        bit           full;
        bit           empty;
        pos        = int'(idx);
        full       = list_fill >= CAPACITY;
        empty      = list_fill == 0;
        res.op     = op;
        res.data   = '0;
        res.status = bal_pkg::ST_OK;
        case (op) inside
            bal_pkg::OP_APPEND: begin
                if (full) begin
                    res.status = bal_pkg::ST_FULL;
                end else begin
                    list_words[list_fill] = val;
                    list_fill++;
                end
            end
            bal_pkg::OP_PREPEND, bal_pkg::OP_INSERT: begin
                if (op == bal_pkg::OP_PREPEND) pos = 0;
                if (full) begin
                    res.status = bal_pkg::ST_FULL;
                end else if (pos > list_fill) begin
                    res.status = bal_pkg::ST_BADIDX;
                end else begin
                    // open a slot: later words move up one place
                    for (int i = list_fill; i > pos; i--) list_words[i] = list_words[i-1];
                    list_words[pos] = val;
                    list_fill++;
                end
            end
            bal_pkg::OP_REMOVE, bal_pkg::OP_DEQUEUE, bal_pkg::OP_READ: begin
                if (op == bal_pkg::OP_DEQUEUE) pos = 0;
                if (empty) begin
                    res.status = bal_pkg::ST_EMPTY;
                end else if (pos >= list_fill) begin
                    res.status = bal_pkg::ST_BADIDX;
                end else begin
                    res.data = list_words[pos];
                    if (op != bal_pkg::OP_READ) begin
                        // close the slot: later words move down one place
                        for (int i = pos; i + 1 < list_fill; i++)
                            list_words[i] = list_words[i+1];
                        list_fill--;
                    end
                end
            end
            bal_pkg::OP_POP: begin
                if (empty) begin
                    res.status = bal_pkg::ST_EMPTY;
                end else begin
                    res.data = list_words[list_fill-1];
                    list_fill--;
                end
            end
            default: begin
                list_fill = 0;
            end
        endcase
        res.count = bal_pkg::CNT_W'(list_fill);
        return res;
    endfunction

    // Watch both channels: retire results first, then predict the new transaction
    always @(posedge i_clk) begin : watch_channels
        t_list_result               want;
        logic [bal_pkg::WORD_W-1:0] got_data;
        logic [bal_pkg::CNT_W-1:0]  got_count;
        logic [bal_pkg::STAT_W-1:0] got_status;
        got_data   = i_m_tdata[bal_pkg::WORD_W-1:0];
        got_count  = i_m_tdata[bal_pkg::WORD_W +: bal_pkg::CNT_W];
        got_status = i_m_tdata[bal_pkg::WORD_W+bal_pkg::CNT_W +: bal_pkg::STAT_W];
        if (i_rst_n) begin
            if (i_m_tvalid && i_m_tready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result", got_data, '0);
                end else begin
                    want = pending_results.pop_front();
                    if (got_data !== want.data)
                        report_mismatch($sformatf("data (op %0d)", want.op),
                                        got_data, want.data);
                    if (got_count !== want.count)
                        report_mismatch($sformatf("count (op %0d)", want.op),
                                        bal_pkg::WORD_W'(got_count),
                                        bal_pkg::WORD_W'(want.count));
                    if (got_status !== want.status)
                        report_mismatch($sformatf("status (op %0d)", want.op),
                                        bal_pkg::WORD_W'(got_status),
                                        bal_pkg::WORD_W'(want.status));
                end
            end
            if (i_s_tvalid && i_s_tready)
                pending_results.push_back(apply_list_op(
                    i_s_tdata[bal_pkg::OP_W-1:0],
                    i_s_tdata[bal_pkg::OP_W +: bal_pkg::IDX_W],
                    i_s_tdata[bal_pkg::OP_W+bal_pkg::IDX_W +: bal_pkg::WORD_W]));
        end else begin
            // Empty the list copy and drop outstanding results while in reset
            list_fill = 0;
            pending_results.delete();
        end
        o_pending    <= pending_results.size();
        o_list_count <= list_fill;
    end

endmodule

// ----- verif/tb_bounded_array_list.sv -----
// Testbench top for the bounded array list: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 100ps

module tb_bounded_array_list;

    localparam int CAPACITY       = bal_pkg::DEF_CAPACITY;
    localparam int ITEM_TARGET    = 1750;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 20;
    localparam int PAD_W          = bal_pkg::S_DATA_W - bal_pkg::OP_W - bal_pkg::IDX_W
                                    - bal_pkg::WORD_W;

    typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIXED, MODE_NOISE} t_traffic_mode;

    logic                         i_clk      = 1'b0;
    logic                         i_rst_n    = 1'b0;
    logic                         i_s_tvalid = 1'b0;
    logic                         o_s_tready;
    logic [bal_pkg::S_DATA_W-1:0] i_s_tdata  = '0;
    logic                         o_m_tvalid;
    logic                         i_m_tready = 1'b0;
    logic [bal_pkg::M_DATA_W-1:0] o_m_tdata;

    int pending;
    int list_count;
    int fail_count;
    int items_sent  = 0;
    int idle_cycles = 0;

    always #5 i_clk = ~i_clk;

    bounded_array_list #(.CAPACITY(CAPACITY)) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    bal_list_checker #(.CAPACITY(CAPACITY)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .o_pending    (pending),
        .o_list_count (list_count),
        .o_fail_count (fail_count)
    );

    // Gap length: mostly short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Operation mix per traffic mode
    function automatic logic [bal_pkg::OP_W-1:0] pick_op(input t_traffic_mode mode);
        int r;
        if (mode == MODE_NOISE) return bal_pkg::OP_W'($urandom_range(0, 7));
        r = $urandom_range(0, 99);
        case (mode)
            MODE_FILL: begin
                if (r < 30) return bal_pkg::OP_APPEND;
                if (r < 50) return bal_pkg::OP_PREPEND;
                if (r < 78) return bal_pkg::OP_INSERT;
                if (r < 83) return bal_pkg::OP_REMOVE;
                if (r < 87) return bal_pkg::OP_POP;
                if (r < 91) return bal_pkg::OP_DEQUEUE;
                return bal_pkg::OP_READ;
            end
            MODE_DRAIN: begin
                if (r < 8)  return bal_pkg::OP_APPEND;
                if (r < 13) return bal_pkg::OP_PREPEND;
                if (r < 20) return bal_pkg::OP_INSERT;
                if (r < 45) return bal_pkg::OP_REMOVE;
                if (r < 65) return bal_pkg::OP_POP;
                if (r < 85) return bal_pkg::OP_DEQUEUE;
                if (r < 98) return bal_pkg::OP_READ;
                return bal_pkg::OP_CLEAR;
            end
            default: begin
                if (r < 18) return bal_pkg::OP_APPEND;
                if (r < 30) return bal_pkg::OP_PREPEND;
                if (r < 48) return bal_pkg::OP_INSERT;
                if (r < 64) return bal_pkg::OP_REMOVE;
                if (r < 74) return bal_pkg::OP_POP;
                if (r < 84) return bal_pkg::OP_DEQUEUE;
                if (r < 98) return bal_pkg::OP_READ;
                return bal_pkg::OP_CLEAR;
            end
        endcase
    endfunction

    // Position: mostly inside the current list, sometimes anywhere in range
    function automatic logic [bal_pkg::IDX_W-1:0] pick_index(
        input logic [bal_pkg::OP_W-1:0] op);
        if ($urandom_range(0, 99) < 85) begin
            if (op == bal_pkg::OP_INSERT)
                return bal_pkg::IDX_W'($urandom_range(0, list_count));
            if ((op == bal_pkg::OP_REMOVE || op == bal_pkg::OP_READ) && list_count > 0)
                return bal_pkg::IDX_W'($urandom_range(0, list_count - 1));
        end
        return bal_pkg::IDX_W'($urandom_range(0, CAPACITY));
    endfunction

    // Word to store: extremes now and then, otherwise random
    function automatic logic [bal_pkg::WORD_W-1:0] pick_word();
        case ($urandom_range(0, 39))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Offer one operation, hold it until taken, then sometimes idle for a while
    task automatic send_op(input logic [bal_pkg::OP_W-1:0] op,
                           input logic [bal_pkg::IDX_W-1:0] idx,
                           input logic [bal_pkg::WORD_W-1:0] val, input bit no_gaps);
        int gap;
        i_s_tdata  <= {{PAD_W{1'b0}}, val, idx, op};
        i_s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        items_sent++;
        gap = (no_gaps || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Hold the sender until every outstanding result has been taken
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Receiver back-pressure, with calm stretches in between
    int stall_left  = 0;
    int regime_left = 0;
    bit calm        = 1'b0;

    always @(posedge i_clk) begin : sink_ready
        int len;
        if (regime_left == 0) begin
            calm        <= ($urandom_range(0, 3) == 0);
            regime_left <= $urandom_range(100, 400);
        end else begin
            regime_left <= regime_left - 1;
        end
        if (stall_left > 0) begin
            i_m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 3) == 0) begin
            len = pick_gap();
            i_m_tready <= 1'b0;
            stall_left <= len - 1;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("** bounded_array_list: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        t_traffic_mode            mode;
        int                       phase_len;
        int                       r;
        bit                       no_gaps;
        logic [bal_pkg::OP_W-1:0] op;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty list: every taking operation answers empty, clear still succeeds
        send_op(bal_pkg::OP_POP,     7'd0,  32'h0, 1'b0);
        send_op(bal_pkg::OP_DEQUEUE, 7'd0,  32'h0, 1'b0);
        send_op(bal_pkg::OP_REMOVE,  7'd64, 32'h0, 1'b0);
        send_op(bal_pkg::OP_READ,    7'd0,  32'h0, 1'b0);
        send_op(bal_pkg::OP_CLEAR,   7'd0,  32'h0, 1'b0);
        send_op(bal_pkg::OP_INSERT,  7'd1,  32'h1234_5678, 1'b0);
        // Build a short list from the extremes, insert at the count goes to the tail
        send_op(bal_pkg::OP_INSERT,  7'd0,  32'h8000_0000, 1'b0);
        send_op(bal_pkg::OP_APPEND,  7'd0,  32'h7FFF_FFFF, 1'b0);
        send_op(bal_pkg::OP_PREPEND, 7'd0,  32'hFFFF_FFFF, 1'b0);
        send_op(bal_pkg::OP_INSERT,  7'd3,  32'h0000_0000, 1'b0);
        send_op(bal_pkg::OP_INSERT,  7'd64, 32'h5555_5555, 1'b0);
        // Reads and removals inside and past the last element
        send_op(bal_pkg::OP_READ,    7'd2,  32'h0, 1'b0);
        send_op(bal_pkg::OP_READ,    7'd4,  32'h0, 1'b0);
        send_op(bal_pkg::OP_READ,    7'd64, 32'h0, 1'b0);
        send_op(bal_pkg::OP_REMOVE,  7'd1,  32'h0, 1'b0);
        send_op(bal_pkg::OP_REMOVE,  7'd3,  32'h0, 1'b0);
        send_op(bal_pkg::OP_DEQUEUE, 7'd0,  32'h0, 1'b0);
        send_op(bal_pkg::OP_POP,     7'd0,  32'h0, 1'b0);
        send_op(bal_pkg::OP_APPEND,  7'd0,  32'hAAAA_AAAA, 1'b0);
        send_op(bal_pkg::OP_READ,    7'd63, 32'h0, 1'b0);
        send_op(bal_pkg::OP_CLEAR,   7'd0,  32'h0, 1'b0);
        send_op(bal_pkg::OP_READ,    7'd0,  32'h0, 1'b0);
        send_op(bal_pkg::OP_APPEND,  7'd0,  32'h5A5A_A5A5, 1'b0);
        send_op(bal_pkg::OP_REMOVE,  7'd0,  32'h0, 1'b0);

        wait_drained();

        // Random phases: fill to capacity, drain to empty, mixed traffic, noise
        while (items_sent < ITEM_TARGET) begin
            r = $urandom_range(0, 9);
            mode = (r < 3) ? MODE_FILL : (r < 6) ? MODE_DRAIN :
                   (r < 9) ? MODE_MIXED : MODE_NOISE;
            phase_len = $urandom_range(40, 160);
            no_gaps   = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < phase_len; k++) begin
                op = pick_op(mode);
                send_op(op, pick_index(op), pick_word(), no_gaps);
            end
            if ($urandom_range(0, 3) == 0) wait_drained();
        end

        // Drain, let the pipeline settle, then give the verdict
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("** bounded_array_list: PASSED **");
        end else begin
            $display("** bounded_array_list: FAILED **");
        end
        $finish;
    end

endmodule
